// ===== hdl/tcaoq_pkg.sv =====
// Shared types and constants of the two-class age-ordered queue.
`timescale 1ns / 1ps

package tcaoq_pkg;

   // Entries in each class queue.
   localparam int DEPTH = 64;
   // Stored tag width.
   localparam int TAG_BITS = 16;
   // Width of the wrapping arrival sequence number.
   localparam int SEQ_BITS = 16;
   // Occupancy counter width, able to hold DEPTH itself.
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // Request operation codes.
   typedef enum logic [1:0] {
      FUNC_ENQUEUE      = 2'd0,
      FUNC_DEQ_NAMED    = 2'd1,
      FUNC_DEQ_OLDEST   = 2'd2
   } func_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_ENQUEUED   = 2'd0,
      STATUS_DEQUEUED   = 2'd1,
      STATUS_EMPTY      = 2'd2,
      STATUS_FULL       = 2'd3
   } status_type;

   // Item classes.
   localparam logic KIND_FIRST  = 1'b0;
   localparam logic KIND_SECOND = 1'b1;

   // One stored entry: tag and arrival sequence number.
   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [SEQ_BITS-1:0] seq;
   } entry_type;

   // Commands from the top level to one class queue.
   typedef struct packed {
      logic push;
      logic pop;
   } lane_ctrl_type;

   // Status of one class queue toward the top level.
   typedef struct packed {
      logic      empty;
      logic      full;
      entry_type head;
   } lane_stat_type;

endpackage

// ===== hdl/tcaoq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

// Request channel: one beat is one queue operation.
interface tcaoq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic        kind;
   logic [15:0] tag;

   modport source (output valid, output func, output kind, output tag, input ready);
   modport sink   (input valid, input func, input kind, input tag, output ready);
endinterface

// Response channel: one beat per accepted request.
interface tcaoq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        out_kind;
   logic [15:0] out_tag;

   modport source (output valid, output status, output out_kind, output out_tag,
                   input ready);
   modport sink   (input valid, input status, input out_kind, input out_tag,
                   output ready);
endinterface

// ===== hdl/tcaoq_cell.sv =====
// One storage cell of a shifting queue chain.
`timescale 1ns / 1ps

module tcaoq_cell (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 shift,
   input  tcaoq_pkg::entry_type wr_entry,
   input  tcaoq_pkg::entry_type next_entry,
   output tcaoq_pkg::entry_type entry
);

   tcaoq_pkg::entry_type entry_ff;
   tcaoq_pkg::entry_type entry_in;

   // A pop moves the entry of the neighbor toward the head; a push fills the tail cell.
   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = next_entry;
      end else if (load) begin
         entry_in = wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/tcaoq_lane.sv =====
// One class queue built as a chain of cells with the head in cell zero.
`timescale 1ns / 1ps

module tcaoq_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  tcaoq_pkg::lane_ctrl_type ctrl,
   input  tcaoq_pkg::entry_type     wr_entry,
   output tcaoq_pkg::lane_stat_type stat
);

   logic [tcaoq_pkg::CNT_BITS-1:0] count_ff;
   logic [tcaoq_pkg::CNT_BITS-1:0] count_in;
   tcaoq_pkg::entry_type           cell_data [tcaoq_pkg::DEPTH];

   // The chain of cells; the last cell holds its own value on a shift.
   for (genvar i = 0; i < tcaoq_pkg::DEPTH; i++) begin : g_cell
      tcaoq_pkg::entry_type neighbor;
      logic                 at_tail;

      if (i == tcaoq_pkg::DEPTH - 1) begin : g_last
         assign neighbor = cell_data[i];
      end else begin : g_mid
         assign neighbor = cell_data[i + 1];
      end

      assign at_tail = (count_ff == tcaoq_pkg::CNT_BITS'(i));

      tcaoq_cell u_cell (
         .clock      (clock),
         .load       (ctrl.push && at_tail),
         .shift      (ctrl.pop),
         .wr_entry   (wr_entry),
         .next_entry (neighbor),
         .entry      (cell_data[i])
      );
   end

   // Occupancy tracks pushes and pops; the top level never issues both at once.
   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + tcaoq_pkg::CNT_BITS'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - tcaoq_pkg::CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == tcaoq_pkg::CNT_BITS'(tcaoq_pkg::DEPTH));
   assign stat.head  = cell_data[0];

endmodule

// ===== hdl/two_class_age_ordered_queue.sv =====
// Top level of the two-class age-ordered queue.
`timescale 1ns / 1ps

// Two queues of DEPTH entries, one per item class, each a chain of cells that
// shift toward the head in cell zero on a pop and fill the cell at the current
// occupancy on a push. Every entry carries its tag and a sequence number from a
// shared wrapping arrival counter that starts at one and advances only on a
// successful enqueue. A dequeue-oldest takes the head whose sequence number is
// older by the sign of the wrapping difference, the first class on a tie. Each
// request yields exactly one response beat. The block takes one request per
// clock cycle: the operation is decided from the two head cells in the cycle of
// acceptance and the response leaves through a one-beat output register, so a
// request is answered in the cycle after it is accepted, and the request side
// stalls only while that register holds a beat the sink has not taken. An
// enqueue into a full class is answered as full and dropped; reset empties both
// queues at once.
module two_class_age_ordered_queue (
   input  logic       clock,
   input  logic       reset,
   tcaoq_req_if.sink   req_bus,
   tcaoq_rsp_if.source rsp_bus
);

   tcaoq_pkg::lane_ctrl_type       first_ctrl;
   tcaoq_pkg::lane_ctrl_type       second_ctrl;
   tcaoq_pkg::lane_stat_type       first_stat;
   tcaoq_pkg::lane_stat_type       second_stat;
   tcaoq_pkg::entry_type           wr_entry;

   logic [tcaoq_pkg::SEQ_BITS-1:0] arrival_ff;
   logic [tcaoq_pkg::SEQ_BITS-1:0] arrival_in;
   logic [tcaoq_pkg::SEQ_BITS-1:0] seq_diff;
   logic                           first_older;
   logic                           accept;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   tcaoq_pkg::status_type          status_ff;
   tcaoq_pkg::status_type          status_in;
   logic                           kind_ff;
   logic                           kind_in;
   logic [15:0]                    tag_ff;
   logic [15:0]                    tag_in;

   // A new request is taken whenever the output register is free or draining.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Entry written on an enqueue.
   assign wr_entry.tag = tcaoq_pkg::TAG_BITS'(req_bus.tag);
   assign wr_entry.seq = arrival_ff;

   // Age compare of the two heads by the sign of the wrapping difference.
   assign seq_diff    = first_stat.head.seq - second_stat.head.seq;
   assign first_older = (seq_diff == '0) || seq_diff[tcaoq_pkg::SEQ_BITS-1];

   // Decode the request into queue commands and the response fields.
   always_comb begin
      first_ctrl  = '0;
      second_ctrl = '0;
      arrival_in  = arrival_ff;
      status_in   = tcaoq_pkg::STATUS_EMPTY;
      kind_in     = tcaoq_pkg::KIND_FIRST;
      tag_in      = '0;
      case (tcaoq_pkg::func_type'(req_bus.func))
         tcaoq_pkg::FUNC_ENQUEUE: begin
            kind_in = req_bus.kind;
            if ((req_bus.kind == tcaoq_pkg::KIND_FIRST) ? first_stat.full
                                                        : second_stat.full) begin
               status_in = tcaoq_pkg::STATUS_FULL;
            end else begin
               status_in        = tcaoq_pkg::STATUS_ENQUEUED;
               first_ctrl.push  = (req_bus.kind == tcaoq_pkg::KIND_FIRST);
               second_ctrl.push = (req_bus.kind == tcaoq_pkg::KIND_SECOND);
               arrival_in       = arrival_ff + tcaoq_pkg::SEQ_BITS'(1);
            end
         end
         tcaoq_pkg::FUNC_DEQ_NAMED: begin
            kind_in = req_bus.kind;
            if (req_bus.kind == tcaoq_pkg::KIND_FIRST) begin
               if (!first_stat.empty) begin
                  status_in      = tcaoq_pkg::STATUS_DEQUEUED;
                  first_ctrl.pop = 1'b1;
                  tag_in         = 16'(first_stat.head.tag);
               end
            end else begin
               if (!second_stat.empty) begin
                  status_in       = tcaoq_pkg::STATUS_DEQUEUED;
                  second_ctrl.pop = 1'b1;
                  tag_in          = 16'(second_stat.head.tag);
               end
            end
         end
         tcaoq_pkg::FUNC_DEQ_OLDEST: begin
            if (!first_stat.empty && (second_stat.empty || first_older)) begin
               status_in      = tcaoq_pkg::STATUS_DEQUEUED;
               kind_in        = tcaoq_pkg::KIND_FIRST;
               first_ctrl.pop = 1'b1;
               tag_in         = 16'(first_stat.head.tag);
            end else if (!second_stat.empty) begin
               status_in       = tcaoq_pkg::STATUS_DEQUEUED;
               kind_in         = tcaoq_pkg::KIND_SECOND;
               second_ctrl.pop = 1'b1;
               tag_in          = 16'(second_stat.head.tag);
            end
         end
         default: begin
            status_in = tcaoq_pkg::STATUS_EMPTY;
         end
      endcase
      // Nothing changes unless the request beat is actually taken.
      if (!accept) begin
         first_ctrl  = '0;
         second_ctrl = '0;
         arrival_in  = arrival_ff;
      end
   end

   // Output register occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         arrival_ff   <= tcaoq_pkg::SEQ_BITS'(1);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         arrival_ff   <= arrival_in;
      end
   end

   // Response payload register, loaded with each accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         tag_ff    <= tag_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = status_ff;
   assign rsp_bus.out_kind = kind_ff;
   assign rsp_bus.out_tag  = tag_ff;

   // The two class queues.
   tcaoq_lane u_first_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (first_ctrl),
      .wr_entry (wr_entry),
      .stat     (first_stat)
   );

   tcaoq_lane u_second_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (second_ctrl),
      .wr_entry (wr_entry),
      .stat     (second_stat)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the two-class age-ordered queue.
`timescale 1ns / 1ps

module tb;
   import tcaoq_pkg::*;

   // The operation code that the block has no use for; it must leave all state alone.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // Cycles without any beat on either channel before the run is abandoned.
   localparam int QUIET_LIMIT = 4000;
   // Length of the long receiver hold-off.
   localparam int HOLD_CYCLES = 300;

   // One response beat as the predictor expects it.
   typedef struct packed {
      status_type  status;
      logic        kind;
      logic [15:0] tag;
   } reply_type;

   // Tracks both class queues and the arrival counter, predicts every response and
   // compares the response beats against the predictions in order.
   class age_queue_scoreboard;
      entry_type first_lane[$];
      entry_type second_lane[$];
      logic [SEQ_BITS-1:0] arrival_seq;
      reply_type awaited[$];
      int mismatches;

      function new();
         arrival_seq = SEQ_BITS'(1);
         mismatches = 0;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // Pops the head of one class, or reports that class as empty.
      function reply_type take_head(logic cls);
         reply_type r;
         entry_type e;
         r.status = STATUS_DEQUEUED;
         r.kind = cls;
         r.tag = '0;
         if (cls == KIND_FIRST && first_lane.size() != 0) begin
            e = first_lane.pop_front();
         end else if (cls == KIND_SECOND && second_lane.size() != 0) begin
            e = second_lane.pop_front();
         end else begin
            r.status = STATUS_EMPTY;
            return r;
         end
         r.tag = 16'(e.tag);
         return r;
      endfunction

      // Applies one accepted request beat and queues the response it must cause.
      function void note_request(logic [1:0] op, logic cls, logic [15:0] handle);
         reply_type r;
         entry_type e;
         logic [SEQ_BITS-1:0] age_gap;
         r.status = STATUS_EMPTY;
         r.kind = KIND_FIRST;
         r.tag = '0;
         case (op)
            FUNC_ENQUEUE: begin
               r.kind = cls;
               if ((cls == KIND_FIRST ? first_lane.size() : second_lane.size()) >= DEPTH) begin
                  // A full class drops the item and the counter stays put.
                  r.status = STATUS_FULL;
               end else begin
                  e.tag = handle[TAG_BITS-1:0];
                  e.seq = arrival_seq;
                  if (cls == KIND_FIRST) first_lane.push_back(e);
                  else second_lane.push_back(e);
                  arrival_seq = arrival_seq + 1'b1;
                  r.status = STATUS_ENQUEUED;
               end
            end
            FUNC_DEQ_NAMED: r = take_head(cls);
            FUNC_DEQ_OLDEST: begin
               if (first_lane.size() == 0 && second_lane.size() == 0) begin
                  r.status = STATUS_EMPTY;
               end else if (first_lane.size() == 0) begin
                  r = take_head(KIND_SECOND);
               end else if (second_lane.size() == 0) begin
                  r = take_head(KIND_FIRST);
               end else begin
                  // The older head wins by the sign of the wrapping difference;
                  // a tie goes to the first class.
                  age_gap = first_lane[0].seq - second_lane[0].seq;
                  if (age_gap == '0 || age_gap[SEQ_BITS-1]) r = take_head(KIND_FIRST);
                  else r = take_head(KIND_SECOND);
               end
            end
            default: r.status = STATUS_EMPTY;
         endcase
         awaited.push_back(r);
      endfunction

      // Compares one response beat with the oldest prediction.
      function void check_reply(logic [1:0] status, logic cls, logic [15:0] handle);
         reply_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with nothing outstanding: status %0d kind %0d tag %h",
                        $realtime, status, cls, handle);
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status || cls !== want.kind || handle !== want.tag) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: expected status %0d kind %0d tag %h, got status %0d kind %0d tag %h",
                        $realtime, want.status, want.kind, want.tag, status, cls, handle);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_pending = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   age_queue_scoreboard sb = new();

   tcaoq_req_if req_bus ();
   tcaoq_rsp_if rsp_bus ();

   two_class_age_ordered_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response side: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Observe both channels at each edge; a request beat is noted before any response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.func, req_bus.kind, req_bus.tag);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_reply(rsp_bus.status, rsp_bus.out_kind, rsp_bus.out_tag);
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet_cycles = 0;
      else quiet_cycles++;
   end

   // Give up when the channels have been silent for too long.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Offers one request beat after a random gap and returns once it is taken.
   task automatic send_item(logic [1:0] op, logic cls, logic [15:0] handle);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= op;
      req_bus.kind <= cls;
      req_bus.tag <= handle;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Random tag, with the all-zeros and all-ones values mixed in.
   function automatic logic [15:0] random_tag();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      return 16'($urandom_range(0, 65535));
   endfunction

   // Random traffic in bursts: fill runs that overflow a class, drain runs that
   // empty the queues, mixed runs, and a little noise with the unused code.
   task automatic run_bursts(int budget);
      int sent;
      int pick;
      int burst_len;
      logic cls;
      logic [1:0] op;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 9);
         cls = 1'($urandom_range(0, 1));
         burst_len = (pick < 6) ? $urandom_range(10, 90) : $urandom_range(1, 30);
         for (int i = 0; i < burst_len && sent < budget; i++) begin
            if (pick < 3) begin
               op = ($urandom_range(0, 5) == 0) ? FUNC_DEQ_NAMED : FUNC_ENQUEUE;
               send_item(op, ($urandom_range(0, 7) == 0) ? ~cls : cls, random_tag());
            end else if (pick < 6) begin
               op = ($urandom_range(0, 7) == 0) ? FUNC_ENQUEUE :
                    ($urandom_range(0, 1) ? FUNC_DEQ_OLDEST : FUNC_DEQ_NAMED);
               send_item(op, 1'($urandom_range(0, 1)), random_tag());
            end else if (pick < 9) begin
               send_item(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), random_tag());
            end else begin
               send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), random_tag());
            end
            sent++;
         end
      end
   endtask

   // Main sequence: reset, directed cases, then the random phases.
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_ENQUEUE;
      req_bus.kind <= KIND_FIRST;
      req_bus.tag <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty queues: both named dequeues, dequeue-oldest and the unused code.
      send_item(FUNC_DEQ_NAMED, KIND_FIRST, 16'hFFFF);
      send_item(FUNC_DEQ_NAMED, KIND_SECOND, 16'h0000);
      send_item(FUNC_DEQ_OLDEST, KIND_SECOND, 16'hFFFF);
      send_item(FUNC_UNUSED, KIND_SECOND, 16'hFFFF);
      // Fill both classes with extreme and patterned tags.
      send_item(FUNC_ENQUEUE, KIND_FIRST, 16'h0000);
      send_item(FUNC_ENQUEUE, KIND_SECOND, 16'hFFFF);
      send_item(FUNC_ENQUEUE, KIND_FIRST, 16'hA5A5);
      send_item(FUNC_ENQUEUE, KIND_SECOND, 16'h5A5A);
      send_item(FUNC_ENQUEUE, KIND_SECOND, 16'h0001);
      send_item(FUNC_ENQUEUE, KIND_FIRST, 16'h8000);
      // The unused code must not disturb anything that is stored.
      send_item(FUNC_UNUSED, KIND_FIRST, 16'h1234);
      // Oldest-first across the classes, with a named pop among them.
      send_item(FUNC_DEQ_OLDEST, KIND_SECOND, 16'h0000);
      send_item(FUNC_DEQ_OLDEST, KIND_FIRST, 16'hFFFF);
      send_item(FUNC_DEQ_NAMED, KIND_SECOND, 16'h0000);
      send_item(FUNC_DEQ_OLDEST, KIND_FIRST, 16'h0000);
      // Both classes hold an item, then only the first.
      send_item(FUNC_DEQ_OLDEST, KIND_FIRST, 16'h0000);
      send_item(FUNC_ENQUEUE, KIND_FIRST, 16'h7FFF);
      send_item(FUNC_DEQ_OLDEST, KIND_SECOND, 16'h0000);
      send_item(FUNC_DEQ_OLDEST, KIND_SECOND, 16'h0000);
      send_item(FUNC_DEQ_NAMED, KIND_FIRST, 16'h0000);

      // No idling, with a long receiver hold-off in the middle so the block backs up.
      run_bursts(140);
      hold_pending = 1'b1;
      run_bursts(143);

      // Sender mostly idle; once it stops until every response has come back.
      send_idle_pct = 77;
      run_bursts(140);
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      run_bursts(143);

      // Receiver mostly stalling.
      send_idle_pct = 0;
      recv_stall_pct = 77;
      run_bursts(283);

      // Both sides idle part of the time.
      send_idle_pct = 37;
      recv_stall_pct = 37;
      run_bursts(283);

      // Drain, then leave room for any stray beat to show up.
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tcaoq_pkg.sv
hdl/tcaoq_if.sv
hdl/tcaoq_cell.sv
hdl/tcaoq_lane.sv
hdl/two_class_age_ordered_queue.sv
tb/tb.sv
